### src/pdc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the PPPoE discovery client.
// ---------------------------------------------------------------------------
package pdc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    // request types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_DISC  = 2'd2;
    localparam logic [1:0] REQ_CHECK = 2'd3;

    // discovery codes
    localparam logic [7:0] CODE_PADO = 8'h07;
    localparam logic [7:0] CODE_PADS = 8'h65;
    localparam logic [7:0] CODE_PADT = 8'ha7;
    // wire codes of the packets the client emits (carried as send kinds)
    localparam logic [7:0] CODE_PADI = 8'h09;
    localparam logic [7:0] CODE_PADR = 8'h19;

    // send kinds
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_PADI = 2'd1;
    localparam logic [1:0] SEND_PADR = 2'd2;
    localparam logic [1:0] SEND_PADT = 2'd3;

    // phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_OFFER   = 2'd1;
    localparam logic [1:0] PH_CONFIRM = 2'd2;
    localparam logic [1:0] PH_UP      = 2'd3;

    // register indexes
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRY   = 2'd1;

    localparam logic [7:0] TIMEOUT_RST = 8'd3;
    localparam logic [7:0] RETRY_RST   = 8'd3;

    // event classes produced by the front end
    typedef enum logic [2:0] {
        EV_START,
        EV_TICK,
        EV_PADO,
        EV_PADS,
        EV_PADT,
        EV_CHECK,
        EV_OTHER
    } ev_class_t;

    typedef struct packed {
        ev_class_t    ev;
        logic [47:0]  src_mac;
        logic [15:0]  session_id;
    } ev_entry_t;

endpackage

### src/pdc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdc_front
// Accepts input transactions and classifies them into event classes.
// ---------------------------------------------------------------------------
module pdc_front
    import pdc_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  code,
    input  logic [47:0] src_mac,
    input  logic [15:0] session_id,
    input  logic        q_full,
    output logic        q_push,
    output ev_entry_t   q_entry
);

    ev_class_t ev;

    always_comb
    begin
        unique case (req_type)
            REQ_START: ev = EV_START;
            REQ_TICK:  ev = EV_TICK;
            REQ_DISC:
            begin
                case (code)
                    CODE_PADO: ev = EV_PADO;
                    CODE_PADS: ev = EV_PADS;
                    CODE_PADT: ev = EV_PADT;
                    default:   ev = EV_OTHER;
                endcase
            end
            default:   ev = EV_CHECK;
        endcase
    end

    assign in_stall            = q_full;
    assign q_push              = in_valid && !q_full;
    assign q_entry.ev          = ev;
    assign q_entry.src_mac     = src_mac;
    assign q_entry.session_id  = session_id;

endmodule

### src/pdc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdc_queue
// Short register queue of classified events between front and back end.
// ---------------------------------------------------------------------------
module pdc_queue
    import pdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ev_entry_t push_entry,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output ev_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ev_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/pdc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdc_back
// Discovery state machine: executes one event per cycle unless a stalled
// result blocks the pop, and holds the result in an output register.
// ---------------------------------------------------------------------------
module pdc_back
    import pdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        head_valid,
    input  ev_entry_t   head_entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  send_kind,
    output logic [15:0] current_session,
    output logic        accepted,
    output logic        established,
    output logic        terminated,
    output logic        ppp_tick,
    output logic [1:0]  phase_out
);

    logic [7:0]  timeout_reg;
    logic [7:0]  retry_limit_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  tick_reg, tick_next;
    logic [7:0]  retry_reg, retry_next;
    logic [15:0] held_reg, held_next;
    logic [47:0] mac_reg, mac_next;

    logic        out_valid_reg;
    logic [1:0]  send_reg, send_next;
    logic        acc_reg, acc_next;
    logic        est_reg, est_next;
    logic        term_reg, term_next;
    logic        ptick_reg, ptick_next;

    logic        mac_match;
    logic        sid_match;
    logic [7:0]  tick_inc;

    assign pop       = head_valid && (!out_valid_reg || !out_stall);
    assign mac_match = (head_entry.src_mac == mac_reg);
    assign sid_match = (head_entry.session_id == held_reg);
    assign tick_inc  = tick_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        retry_next = retry_reg;
        held_next  = held_reg;
        mac_next   = mac_reg;
        send_next  = SEND_NONE;
        acc_next   = 1'b0;
        est_next   = 1'b0;
        term_next  = 1'b0;
        ptick_next = 1'b0;
        case (head_entry.ev)
            EV_START:
            begin
                tick_next  = '0;
                retry_next = '0;
                send_next  = SEND_PADI;
                phase_next = PH_OFFER;
            end
            EV_TICK:
            begin
                if (phase_reg == PH_UP)
                begin
                    ptick_next = 1'b1;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    tick_next = tick_inc;
                    if (tick_inc > timeout_reg)
                    begin
                        tick_next = '0;
                        if (retry_reg < retry_limit_reg)
                        begin
                            retry_next = retry_reg + 8'd1;
                            send_next  = (phase_reg == PH_OFFER) ? SEND_PADI : SEND_PADR;
                        end
                        else
                        begin
                            send_next  = SEND_PADT;
                            term_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            EV_PADO:
            begin
                if (phase_reg == PH_OFFER)
                begin
                    mac_next   = head_entry.src_mac;
                    send_next  = SEND_PADR;
                    phase_next = PH_CONFIRM;
                end
            end
            EV_PADS:
            begin
                if (mac_match && phase_reg == PH_CONFIRM)
                begin
                    held_next  = head_entry.session_id;
                    phase_next = PH_UP;
                    est_next   = 1'b1;
                end
            end
            EV_PADT:
            begin
                // session match ends the link in any phase, idle included
                if (mac_match && sid_match)
                begin
                    term_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            EV_CHECK:
            begin
                acc_next = (phase_reg == PH_UP) && sid_match && mac_match;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RST;
            retry_limit_reg <= RETRY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg     <= cfg_data;
                REG_RETRY:   retry_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            retry_reg     <= '0;
            held_reg      <= '0;
            mac_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                retry_reg <= retry_next;
                held_reg  <= held_next;
                mac_reg   <= mac_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            send_reg  <= send_next;
            acc_reg   <= acc_next;
            est_reg   <= est_next;
            term_reg  <= term_next;
            ptick_reg <= ptick_next;
        end
    end

    // session and phase outputs are the held state after the transaction
    assign out_valid       = out_valid_reg;
    assign send_kind       = send_reg;
    assign current_session = held_reg;
    assign accepted        = acc_reg;
    assign established     = est_reg;
    assign terminated      = term_reg;
    assign ppp_tick        = ptick_reg;
    assign phase_out       = phase_reg;

endmodule

### src/pppoe_discovery_client_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pppoe_discovery_client_unit
// Client side of PPPoE discovery: PADI/PADO/PADR/PADS/PADT sequencing.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one event per transaction:
//   start, timer tick, received discovery packet or session header check.
//   Output channel (out_valid/out_stall) returns one result per event, in
//   order: packet kind to send, held session ID, status flags and phase.
//   Registers timeout_ticks (index 0) and retry_limit (index 1) are written
//   through cfg_write/cfg_index/cfg_data while no transaction is in flight.
//   The queue is written at the accepting edge; the back end pops the event
//   and writes its state update into the output register, raising out_valid.
//   Throughput: one event per cycle unless a stalled result blocks the pop;
//   the back end updates its state as each event is popped.
//   Reset: phase idle, counters and held session/MAC cleared, both registers
//   return to 3, queue and output register empty.
//   When the receiver stalls, the result holds; the queue absorbs up to
//   QUEUE_DEPTH events before in_stall rises.
// ---------------------------------------------------------------------------
module pppoe_discovery_client_unit
    import pdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  code,
    input  logic [47:0] src_mac,
    input  logic [15:0] session_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  send_kind,
    output logic [15:0] current_session,
    output logic        accepted,
    output logic        established,
    output logic        terminated,
    output logic        ppp_tick,
    output logic [1:0]  phase_out
);

    logic      q_full;
    logic      q_push;
    ev_entry_t q_entry;
    logic      q_pop;
    logic      head_valid;
    ev_entry_t head_entry;

    pdc_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .code       (code),
        .src_mac    (src_mac),
        .session_id (session_id),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    pdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    pdc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .head_valid      (head_valid),
        .head_entry      (head_entry),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .send_kind       (send_kind),
        .current_session (current_session),
        .accepted        (accepted),
        .established     (established),
        .terminated      (terminated),
        .ppp_tick        (ppp_tick),
        .phase_out       (phase_out)
    );

endmodule
